>>> hw/rtl/tty_line_discipline_core_defines.svh
// Assertion macros used by the tty line discipline checker.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef TTY_LINE_DISCIPLINE_CORE_DEFINES_SVH
`define TTY_LINE_DISCIPLINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define TLD_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tld: property failed");

// Next-cycle implication, disabled during reset
`define TLD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tld: property failed");

`endif

>>> hw/rtl/tld_pkg.sv
// Shared types, codes and helpers of the tty line discipline core.
// No dependencies; imported by every module of the block.
`default_nettype none

package tld_pkg;

	// Buffer sizing: line store and cooked ring have the same depth
	localparam int BUF_DEPTH = 256;
	localparam int PTR_W     = $clog2(BUF_DEPTH);
	localparam logic [PTR_W-1:0] LEN_MAX = PTR_W'(BUF_DEPTH - 1);

	// Command queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Configuration register indexes
	localparam int CFG_IDX_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_CR   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANON    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ECHO     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ADD_CR   = 4'd3;

	// Characters
	localparam logic [7:0] CH_DEL = 8'd127;
	localparam logic [7:0] CH_LF  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;

	// Input operations
	localparam logic [1:0] OP_RECV  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Result kinds
	localparam logic [2:0] KIND_NONE       = 3'd0;
	localparam logic [2:0] KIND_ECHO       = 3'd1;
	localparam logic [2:0] KIND_ERASE      = 3'd2;
	localparam logic [2:0] KIND_OUTPUT     = 3'd3;
	localparam logic [2:0] KIND_READ_BYTE  = 3'd4;
	localparam logic [2:0] KIND_READ_EMPTY = 3'd5;

	// Classified commands handed from front to back
	localparam logic [2:0] CMD_RAW    = 3'd0;
	localparam logic [2:0] CMD_ERASE  = 3'd1;
	localparam logic [2:0] CMD_APPEND = 3'd2;
	localparam logic [2:0] CMD_READ   = 3'd3;
	localparam logic [2:0] CMD_WRITE  = 3'd4;
	localparam logic [2:0] CMD_CRLF   = 3'd5;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data_byte;
	} tld_in_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] out_byte;
		logic       line_end;
		logic       reader_wake;
		logic       last;
	} tld_out_t;

	typedef struct packed {
		logic map_cr_to_lf;
		logic canonical_mode;
		logic echo_enable;
		logic add_cr_on_output;
	} tld_cfg_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] data_byte;
		logic [2:0] echo_kind;
		logic       canon;
	} tld_cmd_t;

	// Advance a buffer pointer with wrap at BUF_DEPTH
	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == LEN_MAX) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/tld_front.sv
// Front end: accepts input beats, maps CR, classifies them into commands.
// Depends on tld_pkg.
`default_nettype none

module tld_front import tld_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire tld_cfg_t cfg,
	input  wire logic     item_valid,
	output logic          item_ready,
	input  wire tld_in_t  item,
	output logic          cmd_valid,
	input  wire logic     cmd_ready,
	output tld_cmd_t      cmd
);

	logic       valid_s1;
	tld_cmd_t   cmd_s1;
	tld_cmd_t   cmd_d;
	logic       keep;
	logic [7:0] rx_byte;

	assign item_ready = !valid_s1 || cmd_ready;
	assign cmd_valid  = valid_s1;
	assign cmd        = cmd_s1;

	// Map CR on receive
	assign rx_byte = (cfg.map_cr_to_lf && item.data_byte == CH_CR) ? CH_LF : item.data_byte;

	// Classify the beat
	always_comb begin
		cmd_d           = '0;
		cmd_d.data_byte = item.data_byte;
		cmd_d.canon     = cfg.canonical_mode;
		keep            = 1'b1;
		case (item.op)
			OP_RECV: begin
				cmd_d.data_byte = rx_byte;
				if (!cfg.canonical_mode) begin
					cmd_d.op = CMD_RAW;
					if (!cfg.echo_enable) begin
						cmd_d.echo_kind = KIND_NONE;
					end else if (rx_byte == CH_DEL) begin
						cmd_d.echo_kind = KIND_ERASE;
					end else begin
						cmd_d.echo_kind = KIND_ECHO;
					end
				end else if (rx_byte == CH_DEL) begin
					cmd_d.op        = CMD_ERASE;
					cmd_d.echo_kind = cfg.echo_enable ? KIND_ERASE : KIND_NONE;
				end else begin
					cmd_d.op        = CMD_APPEND;
					cmd_d.echo_kind = cfg.echo_enable ? KIND_ECHO : KIND_NONE;
				end
			end
			OP_READ: begin
				cmd_d.op = CMD_READ;
			end
			OP_WRITE: begin
				cmd_d.op = (cfg.add_cr_on_output && item.data_byte == CH_LF) ? CMD_CRLF
					: CMD_WRITE;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// Hold the classified command until the queue takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tld_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on tld_pkg.
`default_nettype none

module tld_queue import tld_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire tld_cmd_t push_cmd,
	output logic          pop_valid,
	input  wire logic     pop,
	output tld_cmd_t      pop_cmd
);

	tld_cmd_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tld_back.sv
// Back end: line store, cooked ring, line release copy and result register.
// Depends on tld_pkg.
`default_nettype none

module tld_back import tld_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	output logic          cmd_pop,
	input  wire tld_cmd_t cmd,
	output logic          result_valid,
	input  wire logic     result_ready,
	output tld_out_t      result
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_COPY   = 3'd1;
	localparam logic [2:0] ST_WAKE   = 3'd2;
	localparam logic [2:0] ST_RDWAIT = 3'd3;
	localparam logic [2:0] ST_RDOUT  = 3'd4;
	localparam logic [2:0] ST_LF     = 3'd5;

	logic [7:0]       ring_mem [BUF_DEPTH];
	logic [7:0]       line_mem [BUF_DEPTH];

	logic [2:0]       state_q, state_d;
	logic [PTR_W-1:0] head_q, head_d;
	logic [PTR_W-1:0] tail_q, tail_d;
	logic [PTR_W-1:0] len_q, len_d;
	logic [PTR_W-1:0] cnt_q, cnt_d;
	logic [PTR_W-1:0] total_q, total_d;
	logic             rd_pend_q, rd_pend_d;
	logic [2:0]       echo_q, echo_d;
	logic             canon_q, canon_d;
	logic [7:0]       ring_rd_q;
	logic [7:0]       line_rd_q;
	logic             res_valid_q;
	tld_out_t         res_q, res_d;
	logic             res_load;

	logic             ring_we, ring_re, line_we, line_re;
	logic [7:0]       ring_wd;
	logic [PTR_W-1:0] head_nx, tail_nx;
	logic             ring_full, ring_empty, out_free;

	assign head_nx    = ptr_inc(head_q);
	assign tail_nx    = ptr_inc(tail_q);
	assign ring_full  = head_nx == tail_q;
	assign ring_empty = head_q == tail_q;
	assign out_free   = !res_valid_q || result_ready;
	assign cmd_pop    = (state_q == ST_IDLE) && cmd_valid && out_free;

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Sequence commands and the line release copy
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		len_d     = len_q;
		cnt_d     = cnt_q;
		total_d   = total_q;
		rd_pend_d = 1'b0;
		echo_d    = echo_q;
		canon_d   = canon_q;
		ring_we   = 1'b0;
		ring_wd   = cmd.data_byte;
		ring_re   = 1'b0;
		line_we   = 1'b0;
		line_re   = 1'b0;
		res_load  = 1'b0;
		res_d     = '0;
		res_d.last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					res_d.kind     = cmd.echo_kind;
					res_d.out_byte = (cmd.echo_kind == KIND_ECHO) ? cmd.data_byte : 8'h00;
					case (cmd.op)
						CMD_RAW: begin
							if (!ring_full) begin
								ring_we = 1'b1;
								head_d  = head_nx;
							end
							res_d.reader_wake = 1'b1;
							res_load          = 1'b1;
						end
						CMD_ERASE: begin
							if (len_q != '0) begin
								len_d    = len_q - PTR_W'(1);
								res_load = cmd.echo_kind != KIND_NONE;
							end
						end
						CMD_APPEND: begin
							if (len_q == LEN_MAX) begin
								len_d    = '0;
								res_load = cmd.echo_kind != KIND_NONE;
							end else if (cmd.data_byte == CH_LF) begin
								line_we = 1'b1;
								len_d   = '0;
								total_d = len_q + PTR_W'(1);
								cnt_d   = '0;
								echo_d  = cmd.echo_kind;
								state_d = ST_COPY;
							end else begin
								line_we  = 1'b1;
								len_d    = len_q + PTR_W'(1);
								res_load = cmd.echo_kind != KIND_NONE;
							end
						end
						CMD_READ: begin
							if (ring_empty) begin
								res_d.kind     = KIND_READ_EMPTY;
								res_d.out_byte = 8'h00;
								res_load       = 1'b1;
							end else begin
								ring_re = 1'b1;
								tail_d  = tail_nx;
								canon_d = cmd.canon;
								state_d = ST_RDWAIT;
							end
						end
						CMD_WRITE: begin
							res_d.kind     = KIND_OUTPUT;
							res_d.out_byte = cmd.data_byte;
							res_load       = 1'b1;
						end
						CMD_CRLF: begin
							res_d.kind     = KIND_OUTPUT;
							res_d.out_byte = CH_CR;
							res_d.last     = 1'b0;
							res_load       = 1'b1;
							state_d        = ST_LF;
						end
						default: begin
						end
					endcase
				end
			end
			ST_COPY: begin
				// One byte a cycle; drop the rest once the ring fills
				if (rd_pend_q && ring_full) begin
					state_d = ST_WAKE;
				end else begin
					if (rd_pend_q) begin
						ring_we = 1'b1;
						ring_wd = line_rd_q;
						head_d  = head_nx;
					end
					if (cnt_q != total_q) begin
						line_re   = 1'b1;
						cnt_d     = cnt_q + PTR_W'(1);
						rd_pend_d = 1'b1;
					end else if (!rd_pend_q) begin
						state_d = ST_WAKE;
					end
				end
			end
			ST_WAKE: begin
				if (out_free) begin
					res_d.kind        = echo_q;
					res_d.out_byte    = (echo_q == KIND_ECHO) ? CH_LF : 8'h00;
					res_d.reader_wake = 1'b1;
					res_load          = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_RDWAIT: begin
				state_d = ST_RDOUT;
			end
			ST_RDOUT: begin
				if (out_free) begin
					res_d.kind     = KIND_READ_BYTE;
					res_d.out_byte = ring_rd_q;
					res_d.line_end = canon_q && (ring_rd_q == CH_LF);
					res_load       = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_LF: begin
				if (out_free) begin
					res_d.kind     = KIND_OUTPUT;
					res_d.out_byte = CH_LF;
					res_load       = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			total_q     <= '0;
			rd_pend_q   <= 1'b0;
			echo_q      <= KIND_NONE;
			canon_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			len_q     <= len_d;
			cnt_q     <= cnt_d;
			total_q   <= total_d;
			rd_pend_q <= rd_pend_d;
			echo_q    <= echo_d;
			canon_q   <= canon_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// Cooked ring: write at head, registered read at tail
	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_mem[head_q] <= ring_wd;
		end
		if (ring_re) begin
			ring_rd_q <= ring_mem[tail_q];
		end
	end

	// Line store: write at line length, registered read at copy index
	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[len_q] <= cmd.data_byte;
		end
		if (line_re) begin
			line_rd_q <= line_mem[cnt_q];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/tty_line_discipline_core.sv
// Results pass the front register, a queue entry and the result register, a read with data
// also the ring read and RDWAIT; a canonical line feed copies the line (with LF) one byte a
// cycle. Throughput: one beat a cycle for echo, erase and write beats while results are taken;
// reads with data and line feeds hold the back end. CR+LF writes give two consecutive results.
// Reset (arst_n low): ring and line empty, all four mode bits set; buffers are not cleared.
`default_nettype none

module tty_line_discipline_core import tld_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_ready,
	input  wire tld_in_t              item,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output tld_out_t                  result,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic                 cfg_data
);

	tld_cfg_t cfg_q;
	logic     fe_valid, fe_ready;
	tld_cmd_t fe_cmd;
	logic     q_valid, q_pop;
	tld_cmd_t q_cmd;

	assign cfg_ready = 1'b1;

	// Mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAP_CR: cfg_q.map_cr_to_lf     <= cfg_data;
				CFG_CANON:  cfg_q.canonical_mode   <= cfg_data;
				CFG_ECHO:   cfg_q.echo_enable      <= cfg_data;
				CFG_ADD_CR: cfg_q.add_cr_on_output <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	tld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_valid  (fe_valid),
		.cmd_ready  (fe_ready),
		.cmd        (fe_cmd)
	);

	tld_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_cmd   (fe_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cmd    (q_cmd)
	);

	tld_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_valid),
		.cmd_pop      (q_pop),
		.cmd          (q_cmd),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> hw/rtl/tld_checker.sv
// Port-level checks of the tty line discipline core, bound to the top level.
// Depends on tld_pkg and tty_line_discipline_core_defines.svh.
`default_nettype none

`include "tty_line_discipline_core_defines.svh"

module tld_checker import tld_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     result_valid,
	input wire logic     result_ready,
	input wire tld_out_t result
);

	// Stalled result beat holds
	`TLD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result))

	// Empty read carries no byte and ends its item
	`TLD_ASSERT_IMPL(a_empty_clean, result_valid && result.kind == KIND_READ_EMPTY, result.out_byte == 8'h00 && result.last)

	// Line end only on a read of LF
	`TLD_ASSERT_IMPL(a_line_end, result_valid && result.line_end, result.kind == KIND_READ_BYTE && result.out_byte == CH_LF)

	// Wake only on a final receive result
	`TLD_ASSERT_IMPL(a_wake_recv, result_valid && result.reader_wake, result.last && (result.kind == KIND_NONE || result.kind == KIND_ECHO || result.kind == KIND_ERASE))

endmodule

bind tty_line_discipline_core tld_checker u_tld_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench for tty_line_discipline_core: echo, line editing, cooked ring,
// reads and terminal output, compared beat by beat against an in-bench predictor.
// Depends on tld_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;
	import tld_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int DRAIN_CYCLES   = BUF_DEPTH + 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 120;
	localparam int SESSIONS       = 12;
	localparam int MAX_REPORTS    = 30;

	// Operation code that the core ignores
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_ready;
	tld_in_t              item         = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	tld_out_t             result;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic                 cfg_data     = 1'b0;

	// Predicted tty state and mode bits
	logic [7:0]       cooked_copy [BUF_DEPTH];
	logic [7:0]       line_copy [BUF_DEPTH];
	logic [PTR_W-1:0] pred_head = '0;
	logic [PTR_W-1:0] pred_tail = '0;
	int               line_fill   = 0;
	tld_cfg_t         modes       = '1;

	tld_out_t pending_results[$];

	int items_sent      = 0;
	int results_checked = 0;
	int cfg_writes      = 0;
	int errors          = 0;
	int burst_left      = 0;
	int quiet_cycles    = 0;

	tty_line_discipline_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	// Append one byte to the predicted cooked ring; refuse when full
	function automatic bit cooked_push(input logic [7:0] b);
		if (ptr_inc(pred_head) == pred_tail)
			return 1'b0;
		cooked_copy[pred_head] = b;
		pred_head = ptr_inc(pred_head);
		return 1'b1;
	endfunction

	// Advance the predicted state by one accepted item and queue its result beats
	task automatic predict_response(input tld_in_t x);
		logic [7:0] c;
		tld_out_t   r;
		r = '0;
		r.last = 1'b1;
		c = x.data_byte;
		case (x.op)
			OP_RECV: begin
				if (modes.map_cr_to_lf && c == CH_CR)
					c = CH_LF;
				if (!modes.canonical_mode) begin
					if (modes.echo_enable) begin
						if (c == CH_DEL) begin
							r.kind = KIND_ERASE;
						end else begin
							r.kind = KIND_ECHO;
							r.out_byte = c;
						end
					end
					void'(cooked_push(c));
					r.reader_wake = 1'b1;
					pending_results.push_back(r);
				end else if (c == CH_DEL) begin
					if (line_fill > 0) begin
						line_fill--;
						if (modes.echo_enable) begin
							r.kind = KIND_ERASE;
							pending_results.push_back(r);
						end
					end
				end else begin
					if (modes.echo_enable) begin
						r.kind = KIND_ECHO;
						r.out_byte = c;
					end
					// A byte arriving on a full line throws the whole line away
					if (line_fill >= BUF_DEPTH - 1) begin
						line_fill = 0;
					end else begin
						line_copy[line_fill] = c;
						line_fill++;
						if (c == CH_LF) begin
							for (int i = 0; i < line_fill; i++)
								if (!cooked_push(line_copy[i]))
									break;
							line_fill = 0;
							r.reader_wake = 1'b1;
						end
					end
					if (r.kind != KIND_NONE || r.reader_wake)
						pending_results.push_back(r);
				end
			end
			OP_READ: begin
				if (pred_head == pred_tail) begin
					r.kind = KIND_READ_EMPTY;
				end else begin
					r.kind = KIND_READ_BYTE;
					r.out_byte = cooked_copy[pred_tail];
					r.line_end = modes.canonical_mode && r.out_byte == CH_LF;
					pred_tail = ptr_inc(pred_tail);
				end
				pending_results.push_back(r);
			end
			OP_WRITE: begin
				r.kind = KIND_OUTPUT;
				if (modes.add_cr_on_output && c == CH_LF) begin
					r.out_byte = CH_CR;
					r.last = 1'b0;
					pending_results.push_back(r);
					r.last = 1'b1;
				end
				r.out_byte = c;
				pending_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	// Send one item beat; open a new burst with a random gap when the old one runs out
	task automatic send_item(input logic [1:0] op, input logic [7:0] data);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_valid <= 1'b1;
		item <= {op, data};
		do @(posedge clk); while (!item_ready);
		predict_response({op, data});
		items_sent++;
	endtask

	// Drop valid, drain every pending beat, then let any silent work finish
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register beat; valid stays high for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_MAP_CR: modes.map_cr_to_lf = v;
			CFG_CANON:  modes.canonical_mode = v;
			CFG_ECHO:   modes.echo_enable = v;
			CFG_ADD_CR: modes.add_cr_on_output = v;
			default: ;
		endcase
		cfg_writes++;
	endtask

	// Reprogram all four modes once idle, with one write to an unused index
	task automatic set_modes(input tld_cfg_t m);
		wait_idle();
		write_reg(CFG_MAP_CR, m.map_cr_to_lf);
		write_reg(CFG_CANON, m.canonical_mode);
		write_reg(CFG_IDX_W'($urandom_range(4, 2 ** CFG_IDX_W - 1)), 1'($urandom_range(0, 1)));
		write_reg(CFG_ECHO, m.echo_enable);
		write_reg(CFG_ADD_CR, m.add_cr_on_output);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] printable();
		return 8'($urandom_range(8'h20, 8'h7e));
	endfunction

	function automatic logic [7:0] typed_char();
		case ($urandom_range(0, 9))
			0: return CH_DEL;
			1: return 8'($urandom_range(0, 255));
			default: return printable();
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("[%0t] result %0d: %s is 0x%0h, predicted 0x%0h",
				$time, results_checked, what, got, want);
	endtask

	// Compare each delivered beat with the oldest prediction
	always @(posedge clk) begin
		tld_out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unpredicted beat, kind", result.kind, KIND_NONE);
			end else begin
				want = pending_results.pop_front();
				if (result.kind != want.kind)
					report_mismatch("kind", result.kind, want.kind);
				if (result.out_byte != want.out_byte)
					report_mismatch("out_byte", result.out_byte, want.out_byte);
				if (result.line_end != want.line_end)
					report_mismatch("line_end", result.line_end, want.line_end);
				if (result.reader_wake != want.reader_wake)
					report_mismatch("reader_wake", result.reader_wake, want.reader_wake);
				if (result.last != want.last)
					report_mismatch("last", result.last, want.last);
			end
			results_checked++;
		end
	end

	// Stall the result channel in changing patterns
	initial begin
		int mode;
		int span;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			for (int k = 0; k < span; k++) begin
				@(posedge clk);
				case (mode)
					0: result_ready <= 1'b1;
					1: result_ready <= 1'($urandom_range(0, 1));
					2: result_ready <= (k % 7) > 1;
					default: result_ready <= (k % 40) >= 25;
				endcase
			end
		end
	end

	// End the run when no channel has moved a beat for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles, %0d results outstanding",
					quiet_cycles, pending_results.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// Reset modes: output CR insertion, empty read, line editing and release
	task automatic test_default_modes();
		send_item(OP_WRITE, CH_LF);
		send_item(OP_WRITE, 8'h00);
		send_item(OP_WRITE, 8'hff);
		send_item(OP_WRITE, CH_CR);
		send_item(OP_UNUSED, 8'haa);
		send_item(OP_READ, 8'h55);
		send_item(OP_RECV, CH_DEL);
		send_item(OP_RECV, 8'h61);
		send_item(OP_RECV, CH_DEL);
		send_item(OP_RECV, 8'hff);
		send_item(OP_RECV, 8'h00);
		send_item(OP_RECV, CH_CR);
		repeat (4) send_item(OP_READ, 8'($urandom_range(0, 255)));
	endtask

	// Raw passthrough with DEL and unmapped CR, then silent canonical editing
	task automatic test_mode_variants();
		set_modes('{map_cr_to_lf: 1'b0, canonical_mode: 1'b0, echo_enable: 1'b1,
			add_cr_on_output: 1'b0});
		send_item(OP_RECV, CH_DEL);
		send_item(OP_RECV, CH_CR);
		send_item(OP_WRITE, CH_LF);
		repeat (2) send_item(OP_READ, 8'hff);
		set_modes('{map_cr_to_lf: 1'b1, canonical_mode: 1'b1, echo_enable: 1'b0,
			add_cr_on_output: 1'b1});
		send_item(OP_RECV, 8'h71);
		repeat (2) send_item(OP_RECV, CH_DEL);
		send_item(OP_RECV, 8'h7a);
		send_item(OP_RECV, CH_CR);
		repeat (2) send_item(OP_READ, 8'h00);
	endtask

	// Full ring in raw mode, full line in canonical mode, line feed into a near-full ring
	task automatic test_buffer_limits();
		set_modes('{map_cr_to_lf: 1'b1, canonical_mode: 1'b0, echo_enable: 1'b0,
			add_cr_on_output: 1'b1});
		repeat (BUF_DEPTH + 2) send_item(OP_RECV, 8'($urandom_range(0, 255)));
		repeat (BUF_DEPTH + 1) send_item(OP_READ, 8'($urandom_range(0, 255)));

		set_modes('1);
		repeat (BUF_DEPTH - 1) send_item(OP_RECV, printable());
		send_item(OP_RECV, CH_LF);
		send_item(OP_RECV, 8'h6f);
		send_item(OP_RECV, 8'h6b);
		send_item(OP_RECV, CH_LF);
		repeat (4) send_item(OP_READ, 8'h00);

		set_modes('{map_cr_to_lf: 1'b1, canonical_mode: 1'b0, echo_enable: 1'b0,
			add_cr_on_output: 1'b0});
		repeat (BUF_DEPTH - 6) send_item(OP_RECV, 8'($urandom_range(0, 255)));
		set_modes('1);
		repeat (10) send_item(OP_RECV, printable());
		send_item(OP_RECV, CH_LF);
		repeat (BUF_DEPTH) send_item(OP_READ, 8'($urandom_range(0, 255)));
	endtask

	// Typed lines with edits, read bursts, writes and some noise under varied modes
	task automatic test_random_sessions();
		tld_cfg_t m;
		int       goal;
		int       len;
		for (int s = 0; s < SESSIONS; s++) begin
			if (s == 0)
				m = '1;
			else if (s == 1)
				m = '0;
			else
				m = tld_cfg_t'(4'($urandom_range(0, 15)));
			set_modes(m);
			goal = items_sent + RANDOM_ITEMS / SESSIONS;
			while (items_sent < goal) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						// one typed line, now and then long enough to overflow
						len = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 300)
							: $urandom_range(0, 24);
						repeat (len) send_item(OP_RECV, typed_char());
						case ($urandom_range(0, 5))
							0: ;
							1, 2: send_item(OP_RECV, CH_LF);
							default: send_item(OP_RECV, CH_CR);
						endcase
					end
					5, 6: repeat ($urandom_range(1, 30))
						send_item(OP_READ, 8'($urandom_range(0, 255)));
					7, 8: repeat ($urandom_range(1, 6))
						send_item(OP_WRITE, ($urandom_range(0, 2) == 0) ? CH_LF
							: 8'($urandom_range(0, 255)));
					default: repeat ($urandom_range(1, 4))
						send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
				endcase
			end
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_modes();
		test_mode_variants();
		test_buffer_limits();
		test_random_sessions();
		wait_idle();
		$display("Sent %0d items, checked %0d result beats, made %0d register writes.",
			items_sent, results_checked, cfg_writes);
		$display("Covered reset modes, raw and canonical editing, full ring and line, %s%0d",
			"random sessions; mismatches: ", errors);
		if (errors == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tld_pkg.sv
hw/rtl/tld_front.sv
hw/rtl/tld_queue.sv
hw/rtl/tld_back.sv
hw/rtl/tty_line_discipline_core.sv
hw/rtl/tld_checker.sv
test/testbench.sv
